/* hw/rtl/rhht_pkg.sv */
// rhht_pkg: shared types and codes for the robin hood hash table
// depends on: nothing
`timescale 1ns / 1ps
`default_nettype none
package rhht_pkg;

  localparam logic [1:0] CMD_SET = 2'd0;
  localparam logic [1:0] CMD_GET = 2'd1;
  localparam logic [1:0] CMD_REM = 2'd2;

  // controller -> datapath commands
  typedef struct packed {
    logic load;        // capture the request
    logic rd_pos;      // issue a read at the probe position
    logic rd_next;     // issue a read at position + 1
    logic step;        // advance probe position and distance
    logic wr_value;    // replace value at probe position
    logic wr_carry;    // write carried entry at probe position
    logic swap;        // carried entry takes the resident read out
    logic wr_shift;    // move read entry back one slot
    logic clr_pos;     // clear the slot at the probe position
    logic cnt_inc;
    logic cnt_dec;
    logic set_found;   // record hit, and value for get and remove
    logic set_created;
    logic set_full;
  } rhht_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic       is_set;
    logic       is_get;
    logic       is_rem;
    logic       rd_valid;   // slot read last cycle is occupied
    logic       rd_match;   // slot read matches the request
    logic       rd_poorer;  // resident distance below carried distance
    logic       rd_dist0;   // resident distance is zero
    logic       probe_last; // probe count reached the table size minus one
    logic       table_full;
  } rhht_sts_t;

endpackage
`default_nettype wire

/* hw/rtl/rhht_ctrl.sv */
// rhht_ctrl: command sequencer for lookup, insert and backward-shift remove
// depends on: rhht_pkg
`timescale 1ns / 1ps
`default_nettype none
module rhht_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire rhht_pkg::rhht_sts_t sts,
  output rhht_pkg::rhht_cmd_t   cmd
);
  import rhht_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_LOOK   = 7'b0000010,
    S_LWAIT  = 7'b0000100,
    S_INS    = 7'b0001000,
    S_SHIFT  = 7'b0010000,
    S_RESULT = 7'b0100000,
    S_IWAIT  = 7'b1000000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_RESULT);

  // next state and command decode
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_LOOK;
        end
      end
      // issue read at probe position
      S_LOOK: begin
        cmd.rd_pos = 1'b1;
        state_next = S_LWAIT;
      end
      // examine read data for lookup
      S_LWAIT: begin
        if (!(sts.is_set || sts.is_get || sts.is_rem)) begin
          // unused command code: empty result
          state_next = S_RESULT;
        end else if (sts.rd_valid && sts.rd_match) begin
          cmd.set_found = 1'b1;
          if (sts.is_set) begin
            cmd.wr_value = 1'b1;
            state_next = S_RESULT;
          end else if (sts.is_rem) begin
            cmd.rd_next = 1'b1;
            state_next = S_SHIFT;
          end else begin
            state_next = S_RESULT;
          end
        end else if (!sts.rd_valid || sts.probe_last) begin
          // miss
          if (sts.is_set) begin
            if (sts.table_full) begin
              cmd.set_full = 1'b1;
              state_next = S_RESULT;
            end else begin
              cmd.set_created = 1'b1;
              cmd.load = 1'b1;   // restart at home slot, distance zero
              state_next = S_INS;
            end
          end else begin
            state_next = S_RESULT;
          end
        end else begin
          cmd.step = 1'b1;
          state_next = S_LOOK;
        end
      end
      // issue read for insertion
      S_INS: begin
        cmd.rd_pos = 1'b1;
        state_next = S_IWAIT;
      end
      S_IWAIT: begin
        if (!sts.rd_valid) begin
          cmd.wr_carry = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_next = S_RESULT;
        end else begin
          if (sts.rd_poorer) begin
            cmd.wr_carry = 1'b1;
            cmd.swap = 1'b1;
          end
          cmd.step = 1'b1;
          state_next = S_INS;
        end
      end
      // next slot read is in flight; shift it back or stop
      S_SHIFT: begin
        if (!sts.rd_valid || sts.rd_dist0 || sts.probe_last) begin
          cmd.clr_pos = 1'b1;
          cmd.cnt_dec = 1'b1;
          state_next = S_RESULT;
        end else begin
          cmd.wr_shift = 1'b1;
          cmd.step = 1'b1;
          state_next = S_SHIFT;
        end
      end
      S_RESULT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // a result is only offered from the result state
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_RESULT) else $error("out_valid outside result");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.wr_value, cmd.wr_carry, cmd.wr_shift, cmd.clr_pos}) <= 1)
    else $error("two writes in one cycle");

endmodule
`default_nettype wire

/* hw/rtl/rhht_dp.sv */
// rhht_dp: slot memory, probe position, carried entry and result registers
// depends on: rhht_pkg
`timescale 1ns / 1ps
`default_nettype none
module rhht_dp #(
  parameter int SLOTS      = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [1:0]          cmd_in,
  input  wire logic [31:0]         key,
  input  wire logic [31:0]         key_hash,
  input  wire logic [31:0]         value,
  input  wire rhht_pkg::rhht_cmd_t cmd,
  output rhht_pkg::rhht_sts_t      sts,
  output logic                     found,
  output logic                     created,
  output logic                     full_error,
  output logic [31:0]              value_out
);
  import rhht_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int EW = KEY_BITS + 32 + VALUE_BITS + AW;

  // entry word: {key, hash, value, distance}
  logic [EW-1:0] mem [SLOTS];
  logic [SLOTS-1:0] vbits;
  logic [EW-1:0] rd_data;
  logic          rd_v;

  logic [1:0]            op;
  logic [KEY_BITS-1:0]   rkey;
  logic [31:0]           rhash;
  logic [KEY_BITS-1:0]   ckey;
  logic [31:0]           chash;
  logic [VALUE_BITS-1:0] cval;
  logic [AW-1:0]         cdist;
  logic [AW-1:0]         pos;
  logic [CW-1:0]         probes;
  logic [CW-1:0]         used;

  logic [KEY_BITS-1:0]   d_key;
  logic [31:0]           d_hash;
  logic [VALUE_BITS-1:0] d_val;
  logic [AW-1:0]         d_dist;
  logic [AW-1:0]         pos_inc;
  logic [AW-1:0]         pos_inc2;
  logic [AW-1:0]         rd_sel;
  logic                  rd_en;
  logic [AW-1:0]         wr_addr;
  logic [EW-1:0]         wr_data;
  logic                  wr_en;

  assign {d_key, d_hash, d_val, d_dist} = rd_data;
  assign pos_inc  = (pos == AW'(SLOTS - 1)) ? '0 : pos + AW'(1);
  assign pos_inc2 = (pos_inc == AW'(SLOTS - 1)) ? '0 : pos_inc + AW'(1);

  // read address: probe position, the next slot, or the slot after a shift
  assign rd_en  = cmd.rd_pos | cmd.rd_next | cmd.wr_shift;
  assign rd_sel = cmd.wr_shift ? pos_inc2 : (cmd.rd_next ? pos_inc : pos);

  // write port select
  always_comb begin
    wr_en   = cmd.wr_value | cmd.wr_carry | cmd.wr_shift;
    wr_addr = pos;
    wr_data = {ckey, chash, cval, cdist};
    if (cmd.wr_value) wr_data = {d_key, d_hash, cval, d_dist};
    if (cmd.wr_shift) wr_data = {d_key, d_hash, d_val, d_dist - AW'(1)};
  end

  // slot memory and read valid
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_data <= mem[rd_sel];
      rd_v    <= vbits[rd_sel];
    end
  end

  // occupancy bits and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
      used  <= '0;
    end else begin
      if (cmd.wr_carry) vbits[pos] <= 1'b1;
      if (cmd.clr_pos)  vbits[pos] <= 1'b0;
      if (cmd.cnt_inc)  used <= used + CW'(1);
      if (cmd.cnt_dec)  used <= used - CW'(1);
    end
  end

  // request, carried entry, probe position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (cmd.set_created) begin
        cval <= cval;
      end else begin
        op    <= cmd_in;
        rkey  <= KEY_BITS'(key);
        rhash <= key_hash;
        cval  <= VALUE_BITS'(value);
      end
      ckey   <= cmd.set_created ? rkey : KEY_BITS'(key);
      chash  <= cmd.set_created ? rhash : key_hash;
      pos    <= cmd.set_created ? rhash[AW-1:0] : key_hash[AW-1:0];
      cdist  <= '0;
      probes <= '0;
    end else if (cmd.swap) begin
      ckey  <= d_key;
      chash <= d_hash;
      cval  <= d_val;
      cdist <= d_dist + AW'(1);
      pos   <= pos_inc;
    end else if (cmd.step) begin
      cdist  <= cdist + AW'(1);
      pos    <= pos_inc;
      probes <= probes + CW'(1);
    end else if (cmd.rd_next) begin
      // shift count starts from zero
      probes <= '0;
    end
  end

  assign sts.is_set     = (op == CMD_SET);
  assign sts.is_get     = (op == CMD_GET);
  assign sts.is_rem     = (op == CMD_REM);
  assign sts.rd_valid   = rd_v;
  assign sts.rd_match   = (d_key == rkey) && (d_hash == rhash);
  assign sts.rd_poorer  = (d_dist < cdist);
  assign sts.rd_dist0   = (d_dist == '0);
  assign sts.probe_last = (probes == CW'(SLOTS - 1));
  assign sts.table_full = (used >= CW'(SLOTS));

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.load && !cmd.set_created) begin
      found      <= 1'b0;
      created    <= 1'b0;
      full_error <= 1'b0;
      value_out  <= '0;
    end
    if (cmd.set_found) begin
      found <= 1'b1;
      if (op != CMD_SET) value_out <= 32'(d_val);
    end
    if (cmd.set_created) created    <= 1'b1;
    if (cmd.set_full)    full_error <= 1'b1;
  end

endmodule
`default_nettype wire

/* hw/rtl/robin_hood_hash_table.sv */
// robin_hood_hash_table: open-addressed table with robin hood insertion
// probes: one slot read per step; insert restarts at home slot; remove hit shifts back
// requests: one at a time, the next taken after the result
// reset: rst clears occupancy bits and the entry count at once; no sweep
// depends on: rhht_pkg, rhht_ctrl, rhht_dp
`timescale 1ns / 1ps
`default_nettype none
module robin_hood_hash_table #(
  parameter int SLOTS      = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] key,
  input  wire logic [31:0] key_hash,
  input  wire logic [31:0] value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             found,
  output logic             created,
  output logic             full_error,
  output logic [31:0]      value_out
);
  import rhht_pkg::*;

  rhht_cmd_t c;
  rhht_sts_t s;

  // sequencer
  rhht_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .sts(s), .cmd(c)
  );

  // storage and compare
  rhht_dp #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk, .rst, .cmd_in(cmd), .key, .key_hash, .value, .cmd(c), .sts(s),
    .found, .created, .full_error, .value_out
  );

endmodule
`default_nettype wire
